// ===== design/itp_pkg.sv =====
// Package: shared types, constants and tables of the ISO timestamp parser.
`timescale 1ns / 1ps
package itp_pkg;

  localparam int unsigned MAX_CHARS       = 127;
  localparam int unsigned YEAR_MAX_DIGITS = 6;
  localparam int unsigned FRAC_DIGITS     = 6;

  // Year bias that makes every accepted year non-negative (a whole number of eras).
  localparam logic [20:0] YEAR_BIAS = 21'd1000000;
  // Epoch shift plus the days of the biased eras.
  localparam logic signed [31:0] DAYS_BIAS = 32'sd365961968;
  // Reciprocal of 25 scaled by 2^24, rounded up.
  localparam logic [19:0] RECIP_25    = 20'd671089;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T_UC  = 8'h54;
  localparam logic [7:0] CH_T_LC  = 8'h74;
  localparam logic [7:0] CH_Z_UC  = 8'h5a;
  localparam logic [7:0] CH_Z_LC  = 8'h7a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [4:0] {
    PH_YSIGN, PH_YEAR_POS, PH_YEAR_NEG, PH_MON0, PH_MON1, PH_MONSEP,
    PH_DAY0, PH_DAY1, PH_AFTER_DATE, PH_HOUR0, PH_HOUR1, PH_HSEP,
    PH_MIN0, PH_MIN1, PH_MSEP, PH_SEC0, PH_SEC1, PH_AFTER_TIME,
    PH_FRAC0, PH_FRAC, PH_OFFH0, PH_OFFH1, PH_AFTER_OFFH, PH_OFFM0,
    PH_OFFM1, PH_DONE, PH_ENDED
  } phase_e;

  typedef enum logic [2:0] {
    CS_PARSE, CS_YEAR, CS_DIV, CS_DAYS, CS_SECS, CS_MUL, CS_SUM, CS_OUT
  } ctrl_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take_char;
    logic take_end;
    logic calc_year;
    logic calc_div;
    logic calc_days;
    logic calc_secs;
    logic calc_mul;
    logic calc_sum;
    logic clear;
  } dp_cmd_t;

  // Remainder by 25 of a narrow value (below 256) by reciprocal.
  function automatic logic [4:0] mod25(input logic [7:0] v);
    logic [15:0] q;
    logic [15:0] r;
    q = (16'(v) * 16'd41) >> 10;
    r = 16'(v) - q * 16'd25;
    return r[4:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                      return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  // Day of the year counted from March, for the first day of month m.
  function automatic logic [8:0] march_doy(input logic [3:0] m);
    case (m)
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [16:0] frac_scale(input logic [2:0] n);
    case (n)
      3'd0:    return 17'd100000;
      3'd1:    return 17'd10000;
      3'd2:    return 17'd1000;
      3'd3:    return 17'd100;
      3'd4:    return 17'd10;
      3'd5:    return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

endpackage

// ===== design/itp_if.sv =====
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface itp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] micros_since_epoch;
  logic               malformed;
  modport source (output valid, output micros_since_epoch, output malformed, input ready);
  modport sink   (input valid, input micros_since_epoch, input malformed, output ready);
endinterface

// ===== design/iso_timestamp_parser.sv =====
// Top level: ISO 8601 timestamp parser, controller plus datapath.
// Usage:
//   in_i  carries one text byte per transfer (char_code), or an end marker
//         (end_of_text = 1, char_code ignored), one byte per cycle while in_i is ready.
//   out_o carries one result per end marker: microseconds since the epoch
//         (UTC, wrapping modulo 2^64) and a malformed flag; when malformed
//         the time reads as -1.
//   Steps: after the end-marker transfer the six arithmetic steps (year
//   bias, divide by 25 via reciprocal, day count, seconds, two partial
//   microsecond products, final sum) run one per cycle in the sequencer's
//   states before the result is valid.
//   in_i is not ready while a text's result is computed or waits.
//   If the receiver stalls, the result stays in its register and in_i stays
//   not ready until the result transfer; then all parser state clears.
//   Reset clears the parser to expect a year and drops any pending result.
`timescale 1ns / 1ps
module iso_timestamp_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);
  import itp_pkg::*;

  dp_cmd_t cmd;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_end_i   (in_i.end_of_text),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  itp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .char_code_i(in_i.char_code),
    .micros_o   (out_o.micros_since_epoch),
    .malformed_o(out_o.malformed)
  );

`ifndef SYNTH
  // No new text is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is pending");

  // End marker starts the computation and blocks input
  a_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.end_of_text) |=> (!in_i.ready && !out_o.valid))
    else $error("end marker did not start computation");

  // Result becomes valid when the computation steps after the end marker finish
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.end_of_text) |-> ##7 out_o.valid)
    else $error("result latency wrong");

  // A malformed result carries all ones
  a_bad_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.malformed) |-> (out_o.micros_since_epoch == -64'sd1))
    else $error("malformed result not -1");
`endif

endmodule

// ===== design/itp_ctrl.sv =====
// Sequencer: character intake, result computation steps and result hand-off.
`timescale 1ns / 1ps
module itp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_end_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output itp_pkg::dp_cmd_t cmd_o
);
  import itp_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_PARSE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      CS_PARSE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_end_i) begin
            cmd_o.take_end = 1'b1;
            state_d        = CS_YEAR;
          end else begin
            cmd_o.take_char = 1'b1;
          end
        end
      end
      CS_YEAR: begin
        cmd_o.calc_year = 1'b1;
        state_d         = CS_DIV;
      end
      CS_DIV: begin
        cmd_o.calc_div = 1'b1;
        state_d        = CS_DAYS;
      end
      CS_DAYS: begin
        cmd_o.calc_days = 1'b1;
        state_d         = CS_SECS;
      end
      CS_SECS: begin
        cmd_o.calc_secs = 1'b1;
        state_d         = CS_MUL;
      end
      CS_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = CS_SUM;
      end
      CS_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = CS_OUT;
      end
      CS_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = CS_PARSE;
        end
      end
      default: state_d = CS_PARSE;
    endcase
  end

endmodule

// ===== design/itp_dp.sv =====
// Datapath: character parser registers and the days/microseconds arithmetic.
`timescale 1ns / 1ps
module itp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itp_pkg::dp_cmd_t   cmd_i,
  input  logic [7:0]         char_code_i,
  output logic signed [63:0] micros_o,
  output logic               malformed_o
);
  import itp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [19:0]        acc_q, acc_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [4:0]         m25_q, m25_d;
  logic               leap_q, leap_d;
  logic signed [20:0] year_q, year_d;
  logic [3:0]         month_q, month_d;
  logic [6:0]         day_q, day_d;
  logic [6:0]         hour_q, hour_d;
  logic [6:0]         minute_q, minute_d;
  logic [6:0]         second_q, second_d;
  logic [19:0]        frac_q, frac_d;
  logic signed [17:0] off_q, off_d;
  logic               err_q, err_d;
  logic [7:0]         chars_q, chars_d;

  logic [20:0]        yadj_q;
  logic signed [18:0] sod_q;
  logic [8:0]         doy_q;
  logic [38:0]        qprod_q;
  logic signed [31:0] days_q;
  logic signed [47:0] secs_q;
  logic [43:0]        plo_q;
  logic [39:0]        phi_q;
  logic [63:0]        micros_q;

  logic        is_dig, fail, zone;
  logic [3:0]  dig;
  logic [23:0] acc10_w;
  logic [19:0] acc10;
  logic [4:0]  lim;
  logic        end_ok;

  assign is_dig  = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign dig     = is_dig ? 4'(char_code_i - CH_ZERO) : 4'd0;
  assign acc10_w = 24'(acc_q) * 24'd10 + 24'(dig);
  assign acc10   = acc10_w[19:0];
  assign end_ok  = (phase_q inside {PH_AFTER_DATE, PH_AFTER_TIME, PH_FRAC,
                                    PH_AFTER_OFFH, PH_DONE, PH_ENDED});

  // Character parser next state
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    m25_d    = m25_q;
    leap_d   = leap_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    frac_d   = frac_q;
    off_d    = off_q;
    err_d    = err_q;
    chars_d  = chars_q;
    fail     = 1'b0;
    zone     = 1'b0;
    lim      = month_len(month_q);
    if (month_q == 4'd2 && leap_q) begin
      lim = 5'd29;
    end

    if (cmd_i.clear) begin
      phase_d  = PH_YSIGN;
      acc_d    = '0;
      cnt_d    = '0;
      m25_d    = '0;
      leap_d   = 1'b0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      frac_d   = '0;
      off_d    = '0;
      err_d    = 1'b0;
      chars_d  = '0;
    end else if (cmd_i.take_end) begin
      if (!end_ok) begin
        err_d = 1'b1;
      end
      phase_d = PH_ENDED;
    end else if (cmd_i.take_char) begin
      // Length limit
      if (chars_q >= 8'(MAX_CHARS)) begin
        err_d = 1'b1;
      end else begin
        chars_d = chars_q + 8'd1;
      end
      if (phase_q == PH_ENDED) begin
        phase_d = PH_ENDED;
      end else if (char_code_i == CH_NUL) begin
        // Zero byte ends the text early
        if (!end_ok) begin
          err_d = 1'b1;
        end
        phase_d = PH_ENDED;
      end else begin
        case (phase_q)
          PH_YSIGN: begin
            if (char_code_i == CH_MINUS) begin
              phase_d = PH_YEAR_NEG;
              cnt_d   = 3'd0;
              acc_d   = '0;
              m25_d   = '0;
            end else if (is_dig) begin
              phase_d = PH_YEAR_POS;
              cnt_d   = 3'd1;
              acc_d   = 20'(dig);
              m25_d   = 5'(dig);
            end else begin
              fail = 1'b1;
            end
          end
          PH_YEAR_POS, PH_YEAR_NEG: begin
            if (is_dig) begin
              if (cnt_q >= 3'(YEAR_MAX_DIGITS)) begin
                fail = 1'b1;
              end else begin
                acc_d = acc10;
                cnt_d = cnt_q + 3'd1;
                m25_d = mod25(8'(m25_q) * 8'd10 + 8'(dig));
              end
            end else if (char_code_i == CH_MINUS && cnt_q >= 3'd4) begin
              year_d  = (phase_q == PH_YEAR_NEG) ? -$signed({1'b0, acc_q})
                                                 : $signed({1'b0, acc_q});
              leap_d  = (acc_q[1:0] == 2'd0) && ((m25_q != 5'd0) || (acc_q[3:0] == 4'd0));
              phase_d = PH_MON0;
            end else begin
              fail = 1'b1;
            end
          end
          PH_MON0, PH_DAY0, PH_HOUR0, PH_MIN0, PH_SEC0, PH_OFFH0, PH_OFFM0: begin
            if (!is_dig) begin
              fail = 1'b1;
            end else begin
              acc_d   = 20'(dig);
              phase_d = phase_e'(phase_q + 5'd1);
            end
          end
          PH_MON1: begin
            acc_d = acc10;
            if (!is_dig || acc10 < 20'd1 || acc10 > 20'd12) begin
              fail = 1'b1;
            end else begin
              month_d = acc10[3:0];
              phase_d = PH_MONSEP;
            end
          end
          PH_MONSEP: begin
            if (char_code_i == CH_MINUS) phase_d = PH_DAY0;
            else fail = 1'b1;
          end
          PH_DAY1: begin
            acc_d = acc10;
            if (!is_dig || acc10 < 20'd1 || acc10 > 20'(lim)) begin
              fail = 1'b1;
            end else begin
              day_d   = acc10[6:0];
              phase_d = PH_AFTER_DATE;
            end
          end
          PH_AFTER_DATE: begin
            if (char_code_i == CH_T_UC || char_code_i == CH_T_LC || char_code_i == CH_SPACE) begin
              phase_d = PH_HOUR0;
            end else begin
              zone = 1'b1;
            end
          end
          PH_HOUR1: begin
            if (!is_dig) begin
              fail = 1'b1;
            end else begin
              hour_d  = acc10[6:0];
              phase_d = PH_HSEP;
            end
          end
          PH_HSEP: begin
            if (char_code_i == CH_COLON) phase_d = PH_MIN0;
            else fail = 1'b1;
          end
          PH_MIN1: begin
            if (!is_dig) begin
              fail = 1'b1;
            end else begin
              minute_d = acc10[6:0];
              phase_d  = PH_MSEP;
            end
          end
          PH_MSEP: begin
            if (char_code_i == CH_COLON) phase_d = PH_SEC0;
            else fail = 1'b1;
          end
          PH_SEC1: begin
            if (!is_dig) begin
              fail = 1'b1;
            end else begin
              second_d = acc10[6:0];
              if (hour_q > 7'd23 || minute_q > 7'd59 || acc10[6:0] > 7'd60) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_AFTER_TIME;
              end
            end
          end
          PH_AFTER_TIME: begin
            if (char_code_i == CH_DOT) begin
              phase_d = PH_FRAC0;
              cnt_d   = 3'd0;
              frac_d  = '0;
            end else begin
              zone = 1'b1;
            end
          end
          PH_FRAC0, PH_FRAC: begin
            if (is_dig) begin
              // Digits past microseconds are dropped
              if (cnt_q < 3'(FRAC_DIGITS)) begin
                frac_d = frac_q + 20'(21'(dig) * 21'(frac_scale(cnt_q)));
                cnt_d  = cnt_q + 3'd1;
              end
              phase_d = PH_FRAC;
            end else if (phase_q == PH_FRAC) begin
              zone = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OFFH1: begin
            acc_d = acc10;
            if (!is_dig || acc10 > 20'd23) begin
              fail = 1'b1;
            end else begin
              off_d   = (cnt_q != 3'd0) ? -$signed(18'(acc10[4:0] * SECS_PER_HOUR))
                                        : $signed(18'(acc10[4:0] * SECS_PER_HOUR));
              phase_d = PH_AFTER_OFFH;
            end
          end
          PH_AFTER_OFFH: begin
            if (char_code_i == CH_COLON) begin
              phase_d = PH_OFFM0;
            end else if (is_dig) begin
              acc_d   = 20'(dig);
              phase_d = PH_OFFM1;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OFFM1: begin
            acc_d = acc10;
            if (!is_dig || acc10 > 20'd59) begin
              fail = 1'b1;
            end else begin
              off_d   = (cnt_q != 3'd0) ? off_q - $signed(18'(acc10[5:0] * 12'd60))
                                        : off_q + $signed(18'(acc10[5:0] * 12'd60));
              phase_d = PH_DONE;
            end
          end
          default: fail = 1'b1;
        endcase

        // Zone designator or offset sign ends a field
        if (zone) begin
          if (char_code_i == CH_Z_UC || char_code_i == CH_Z_LC) begin
            phase_d = PH_DONE;
          end else if (char_code_i == CH_PLUS || char_code_i == CH_MINUS) begin
            cnt_d   = (char_code_i == CH_MINUS) ? 3'd1 : 3'd0;
            phase_d = PH_OFFH0;
          end else begin
            fail = 1'b1;
          end
        end
        if (fail) begin
          err_d   = 1'b1;
          phase_d = PH_ENDED;
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YSIGN;
      acc_q    <= '0;
      cnt_q    <= '0;
      m25_q    <= '0;
      leap_q   <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      off_q    <= '0;
      err_q    <= 1'b0;
      chars_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      m25_q    <= m25_d;
      leap_q   <= leap_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      off_q    <= off_d;
      err_q    <= err_d;
      chars_q  <= chars_d;
    end
  end

  // Result arithmetic, one step per command
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_year) begin
      // Biased March-based year, second of day less offset, day of year
      yadj_q <= 21'(22'(year_q) - ((month_q <= 4'd2) ? 22'sd1 : 22'sd0)
                    + $signed({1'b0, YEAR_BIAS}));
      sod_q  <= 19'(20'(hour_q) * 20'(SECS_PER_HOUR) + 20'(minute_q) * 20'd60
                    + 20'(second_q)) - 19'(off_q);
      doy_q  <= march_doy(month_q) + 9'(day_q) - 9'd1;
    end
    if (cmd_i.calc_div) begin
      qprod_q <= 39'(yadj_q[20:2]) * 39'(RECIP_25);
    end
    if (cmd_i.calc_days) begin
      days_q <= $signed(32'(yadj_q) * 32'd365 + 32'(yadj_q[20:2])
                        - 32'(qprod_q[38:RECIP_SHIFT]) + 32'(qprod_q[38:RECIP_SHIFT+2])
                        + 32'(doy_q)) - DAYS_BIAS;
    end
    if (cmd_i.calc_secs) begin
      secs_q <= 48'(days_q * $signed({31'd0, SECS_PER_DAY})) + 48'(sod_q);
    end
    if (cmd_i.calc_mul) begin
      // Upper half carries the sign of the seconds count
      plo_q <= 44'(secs_q[23:0]) * 44'(MICROS_PER_SEC);
      phi_q <= 40'(40'($signed(secs_q[47:24])) * 40'(MICROS_PER_SEC));
    end
    if (cmd_i.calc_sum) begin
      micros_q <= err_q ? '1 : ({phi_q, 24'd0} + 64'(plo_q) + 64'(frac_q));
    end
  end

  assign micros_o    = $signed(micros_q);
  assign malformed_o = err_q;

endmodule
